>>> rtl/page_refcount_run_tracker_defines.svh
// ----------------------------------------------------------------------------
// page_refcount_run_tracker_defines.svh
// assertion macros shared by the page reference-count run tracker
// ----------------------------------------------------------------------------
`ifndef PAGE_REFCOUNT_RUN_TRACKER_DEFINES_SVH
`define PAGE_REFCOUNT_RUN_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PRRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PRRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/prrt_pkg.sv
// ----------------------------------------------------------------------------
// prrt_pkg
// widths, limits and shared types of the page reference-count run tracker
// ----------------------------------------------------------------------------
`default_nettype none

package prrt_pkg;

    // page numbering and counter store
    localparam int PAGE_W    = 16;
    localparam int NUM_PAGES = 2 ** PAGE_W;
    localparam int COUNT_W   = 16;
    localparam int LEN_W     = 17;

    typedef logic [PAGE_W-1:0]  page_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [LEN_W-1:0]   len_t;

    // counter ceiling and run-length saturation
    localparam count_t COUNT_MAX = count_t'(16'hFFFF);
    localparam len_t   LEN_SAT   = '1;

    // write request into the counter store
    typedef struct packed {
        logic   en;
        page_t  addr;
        count_t data;
    } cnt_wr_t;

endpackage

`default_nettype wire

>>> rtl/prrt_ifs.sv
// ----------------------------------------------------------------------------
// prrt_ifs
// valid/ready channels: page update words in, run report words out
// ----------------------------------------------------------------------------
`default_nettype none

interface prrt_upd_if import prrt_pkg::*;;
    logic  valid;
    logic  ready;
    page_t page_index;
    logic  increment;
    logic  first_of_range;
    logic  last_of_range;

    modport source (output valid, output page_index, output increment,
                    output first_of_range, output last_of_range, input ready);
    modport sink   (input valid, input page_index, input increment,
                    input first_of_range, input last_of_range, output ready);
endinterface

interface prrt_rep_if import prrt_pkg::*;;
    logic   valid;
    logic   ready;
    logic   run_valid;
    page_t  run_start_page;
    len_t   run_page_count;
    logic   mark_cached;
    logic   count_fault;
    count_t new_count;

    modport source (output valid, output run_valid, output run_start_page,
                    output run_page_count, output mark_cached, output count_fault,
                    output new_count, input ready);
    modport sink   (input valid, input run_valid, input run_start_page,
                    input run_page_count, input mark_cached, input count_fault,
                    input new_count, output ready);
endinterface

`default_nettype wire

>>> rtl/prrt_count_store.sv
// ----------------------------------------------------------------------------
// prrt_count_store
// per-page counter memory with registered read and a clearing sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_refcount_run_tracker_defines.svh"

module prrt_count_store import prrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rd_en,
    input  page_t   rd_addr,
    output count_t  rd_data,
    input  cnt_wr_t wr,
    output logic    cleared
);

    count_t mem [NUM_PAGES];
    count_t rd_data_reg;
    page_t  clr_addr_reg;
    logic   cleared_reg;

    // clearing sweep, one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            cleared_reg  <= 1'b0;
        end
        else if (!cleared_reg)
        begin
            clr_addr_reg <= clr_addr_reg + page_t'(1);
            if (clr_addr_reg == '1)
            begin
                cleared_reg <= 1'b1;
            end
        end
    end

    // single write port shared by sweep and updates, registered read
    always_ff @(posedge clk)
    begin
        if (!cleared_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign cleared = cleared_reg;

    `PRRT_ASSERT_NOW(a_no_update_in_sweep, wr.en, cleared_reg, "update write during clearing sweep")
    `PRRT_ASSERT_NEXT(a_sweep_ends, !cleared_reg && clr_addr_reg == '1, cleared_reg, "sweep did not finish")
    `PRRT_ASSERT_NEXT(a_cleared_holds, cleared_reg, cleared_reg, "store left cleared state")

endmodule

`default_nettype wire

>>> rtl/page_refcount_run_tracker.sv
// ----------------------------------------------------------------------------
// page_refcount_run_tracker
// per-page reference counts with run merging of 0->1 and ->0 transitions
// ----------------------------------------------------------------------------
// Takes one page update word per cycle while the report port is not stalled
// and gives one report word per update. The rate is set by the counter memory:
// one registered read when the word is taken and one write-back as it leaves
// the update stage, with the written count forwarded when the next word hits
// the same page. After reset the counter memory is swept to zero, one page a
// cycle, and no update is taken until it is done. A stalled report port holds
// the update stage; the output register lets the next word be read meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_refcount_run_tracker_defines.svh"

module page_refcount_run_tracker import prrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    prrt_upd_if.sink    update,
    prrt_rep_if.source  report
);

    logic    cleared;
    logic    in_ready;
    logic    in_acc;
    logic    s1_go;
    count_t  rd_data;
    cnt_wr_t wr;

    // update stage registers
    logic    s1_valid_reg;
    page_t   s1_page_reg;
    logic    s1_inc_reg;
    logic    s1_first_reg;
    logic    s1_last_reg;
    logic    fwd_reg;
    count_t  fwd_data_reg;

    // run state
    logic    run_open_reg,  run_open_next;
    page_t   run_begin_reg, run_begin_next;
    len_t    run_length_reg, run_length_next;
    logic    range_dir_reg, range_dir_next;

    // output register
    logic    out_valid_reg;
    logic    rep_valid_reg, rep_valid_next;
    page_t   rep_start_reg, rep_start_next;
    len_t    rep_len_reg,   rep_len_next;
    logic    rep_dir_reg,   rep_dir_next;
    logic    fault_reg,     fault_next;
    count_t  nc_reg,        nc_next;

    // working values
    count_t  cur;
    logic    ro0;
    len_t    rl0;
    logic    dir0;
    logic    dirchg;
    logic    qual;
    len_t    len_inc;

    // handshake
    assign s1_go        = s1_valid_reg && (!out_valid_reg || report.ready);
    assign in_ready     = cleared && (!s1_valid_reg || s1_go);
    assign update.ready = in_ready;
    assign in_acc       = update.valid && in_ready;

    prrt_count_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_acc),
        .rd_addr (update.page_index),
        .rd_data (rd_data),
        .wr      (wr),
        .cleared (cleared)
    );

    // read stage: capture word, flag forwarding from the write-back in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
            fwd_reg      <= s1_go && (s1_page_reg == update.page_index);
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_page_reg  <= update.page_index;
            s1_inc_reg   <= update.increment;
            s1_first_reg <= update.first_of_range;
            s1_last_reg  <= update.last_of_range;
            fwd_data_reg <= nc_next;
        end
    end

    // counter update and run bookkeeping
    always_comb
    begin
        cur     = fwd_reg ? fwd_data_reg : rd_data;
        ro0     = s1_first_reg ? 1'b0 : run_open_reg;
        rl0     = s1_first_reg ? '0 : run_length_reg;
        dir0    = s1_first_reg ? s1_inc_reg : range_dir_reg;
        dirchg  = ro0 && (s1_inc_reg != dir0);
        len_inc = (rl0 == LEN_SAT) ? rl0 : rl0 + len_t'(1);

        if (s1_inc_reg)
        begin
            fault_next = (cur >= COUNT_MAX);
            nc_next    = fault_next ? cur : cur + count_t'(1);
            qual       = !fault_next && (nc_next == count_t'(1));
        end
        else
        begin
            fault_next = (cur == '0);
            nc_next    = fault_next ? cur : cur - count_t'(1);
            qual       = !fault_next && (nc_next == '0);
        end

        run_open_next   = ro0;
        run_begin_next  = run_begin_reg;
        run_length_next = rl0;
        range_dir_next  = s1_inc_reg;
        rep_valid_next  = 1'b0;
        rep_start_next  = '0;
        rep_len_next    = '0;
        rep_dir_next    = 1'b0;

        priority if (dirchg)
        begin
            rep_valid_next  = 1'b1;
            rep_start_next  = run_begin_reg;
            rep_len_next    = rl0;
            rep_dir_next    = dir0;
            run_open_next   = 1'b0;
            run_length_next = '0;
        end
        else if (qual)
        begin
            if (!ro0)
            begin
                run_open_next   = 1'b1;
                run_begin_next  = s1_page_reg;
                run_length_next = len_t'(1);
            end
            else
            begin
                run_length_next = len_inc;
            end
            if (s1_last_reg)
            begin
                rep_valid_next  = 1'b1;
                rep_start_next  = run_begin_next;
                rep_len_next    = run_length_next;
                rep_dir_next    = s1_inc_reg;
                run_open_next   = 1'b0;
                run_length_next = '0;
            end
        end
        else if (ro0)
        begin
            rep_valid_next  = 1'b1;
            rep_start_next  = run_begin_reg;
            rep_len_next    = rl0;
            rep_dir_next    = s1_inc_reg;
            run_open_next   = 1'b0;
            run_length_next = '0;
        end
        else
        begin
            rep_valid_next = 1'b0;
        end
    end

    // write-back into the counter store
    assign wr.en   = s1_go;
    assign wr.addr = s1_page_reg;
    assign wr.data = nc_next;

    // run state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg   <= 1'b0;
            run_begin_reg  <= '0;
            run_length_reg <= '0;
            range_dir_reg  <= 1'b0;
        end
        else if (s1_go)
        begin
            run_open_reg   <= run_open_next;
            run_begin_reg  <= run_begin_next;
            run_length_reg <= run_length_next;
            range_dir_reg  <= range_dir_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            rep_valid_reg <= rep_valid_next;
            rep_start_reg <= rep_start_next;
            rep_len_reg   <= rep_len_next;
            rep_dir_reg   <= rep_dir_next;
            fault_reg     <= fault_next;
            nc_reg        <= nc_next;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.run_valid      = rep_valid_reg;
    assign report.run_start_page = rep_start_reg;
    assign report.run_page_count = rep_len_reg;
    assign report.mark_cached    = rep_dir_reg;
    assign report.count_fault    = fault_reg;
    assign report.new_count      = nc_reg;

    `PRRT_ASSERT_NOW(a_open_has_length, 1'b1, run_open_reg == (run_length_reg != '0), "run open flag and length disagree")
    `PRRT_ASSERT_NOW(a_fault_keeps_count, s1_go && fault_next, nc_next == cur, "refused update changed the count")
    `PRRT_ASSERT_NEXT(a_result_loaded, s1_go, out_valid_reg, "update finished without a report word")

endmodule

`default_nettype wire
